// File: sv/psd_pkg.sv
// Shared types, register codes and constants for the smoothed-derivative PID block.
`default_nettype none

package psd_pkg;

  localparam int VALUE_WIDTH_DEF = 32;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  localparam int GAIN_W = 32;
  localparam int PER_W  = 31;
  localparam int SF_W   = 17;

  localparam int FRAC_BITS = 16;

  // Multiplier digit: the config operand is consumed this many bits per cycle
  localparam int DIGIT_W    = 8;
  localparam int NUM_DIGITS = GAIN_W / DIGIT_W;
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);
  localparam logic [DIG_CNT_W-1:0] DIG_LAST = DIG_CNT_W'(NUM_DIGITS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP,
    REG_KI,
    REG_KD,
    REG_BIAS,
    REG_PERIOD,
    REG_INV_PERIOD,
    REG_INT_LIMIT,
    REG_SMOOTHING
  } cfg_reg_t;

  localparam logic [PER_W-1:0] PERIOD_RST     = 31'd65536;
  localparam logic [PER_W-1:0] INV_PERIOD_RST = 31'd65536;
  localparam logic [PER_W-1:0] INT_LIMIT_RST  = 31'h7FFF_FFFF;
  localparam logic [SF_W-1:0]  SMOOTHING_RST  = 17'd65536;

  typedef struct packed {
    logic signed [31:0] measured;
    logic signed [31:0] target;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               integral_clamped;
  } out_item_t;

endpackage

`default_nettype wire

// File: sv/pid_smoothed_derivative.sv
// PID controller with smoothed-error derivative and clamped integral, Q16.16.
//
// Input channel (in_valid / in_stall / in_item): one item per control sample,
// holding the measured value and the setpoint. Result channel (out_valid /
// out_stall / out_item): one item per input, the saturated drive and a flag
// set when the integral clamp acted. Config port: cfg_wr_en writes cfg_data
// into register cfg_index (kp, ki, kd, bias, period, inverse_period,
// integral_limit, smoothing weight); write only while the block is idle.
//
// All six Q16.16 products run on one shared multiplier that takes the gain
// operand 8 bits per cycle: each product takes a load step, a digit step for
// each 8-bit digit of the gain operand and a rounding step. The block holds
// one item at a time; in_stall is high from acceptance until the result is
// written to the output register. A finished result waiting under out_stall
// does not block acceptance of the next item; that item waits at its end
// until the output register frees up.
//
// Reset (synchronous, rst_n low) clears integral and smoothed-error state,
// restores register defaults and drops out_valid.
`default_nettype none

module pid_smoothed_derivative
  import psd_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int W  = VALUE_WIDTH;
  localparam int MX = (W > 33) ? W : 33;
  localparam int LW = MX + 2;
  localparam int PW = W + GAIN_W;
  localparam int QW = PW - FRAC_BITS;

  localparam logic signed [LW-1:0] W_MAX_L = {{(LW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [LW-1:0] W_MIN_L = {{(LW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [LW-1:0] D_MAX_L = {{(LW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [LW-1:0] D_MIN_L = {{(LW-31){1'b1}}, {31{1'b0}}};
  localparam logic [QW-1:0] Q_POS_MAX = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [QW-1:0] Q_NEG_MAX = {{(QW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
  localparam logic [QW-1:0] Q_ONE     = {{(QW-1){1'b0}}, 1'b1};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_SMOOTH,
    OP_DERIV,
    OP_INTEG,
    OP_P_TERM,
    OP_I_TERM,
    OP_D_TERM
  } op_t;

  function automatic logic signed [W-1:0] sat_w(input logic signed [LW-1:0] x);
    if (x > W_MAX_L) begin
      return W_MAX_L[W-1:0];
    end else if (x < W_MIN_L) begin
      return W_MIN_L[W-1:0];
    end
    return x[W-1:0];
  endfunction

  // Configuration registers
  logic signed [GAIN_W-1:0] kp_r, ki_r, kd_r, bias_r;
  logic [PER_W-1:0]         period_r, inv_period_r, int_limit_r;
  logic [SF_W-1:0]          smoothing_r;

  // Controller state and per-item working values
  logic signed [W-1:0]  integ_r, prev_r;
  logic signed [W-1:0]  e_r, s_r, d_r, sum_r;
  logic signed [LW-1:0] tot_r;
  logic                 flag_r;

  // Shared digit-serial multiplier
  logic [W-1:0]         a_mag_r;
  logic [GAIN_W-1:0]    b_mag_r;
  logic [PW-1:0]        prod_r;
  logic                 neg_r;
  logic [DIG_CNT_W-1:0] dig_r;

  state_t    state_r;
  op_t       op_r;
  logic      out_valid_r;
  out_item_t out_item_r;

  logic signed [W:0]      op_x;
  logic signed [GAIN_W:0] op_y;
  logic [W:0]             x_abs;
  logic [GAIN_W:0]        y_abs;
  logic [W+DIGIT_W-1:0]   digit_prod;
  logic [W+DIGIT_W-1:0]   step_sum;
  logic [PW-1:0]          prod_nxt;
  logic [QW-1:0]          q_raw, q_max, q_sat;
  logic                   frac_nz;
  logic signed [W-1:0]    m_val;
  logic signed [LW-1:0]   m_ext, prev_ext, integ_ext, err_diff, bias_ext;
  logic signed [LW-1:0]   lim_ext, neg_lim, sum_pre_ext;
  logic signed [W-1:0]    sum_pre;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r         <= '0;
      ki_r         <= '0;
      kd_r         <= '0;
      bias_r       <= '0;
      period_r     <= PERIOD_RST;
      inv_period_r <= INV_PERIOD_RST;
      int_limit_r  <= INT_LIMIT_RST;
      smoothing_r  <= SMOOTHING_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KP:         kp_r         <= cfg_data;
        REG_KI:         ki_r         <= cfg_data;
        REG_KD:         kd_r         <= cfg_data;
        REG_BIAS:       bias_r       <= cfg_data;
        REG_PERIOD:     period_r     <= cfg_data[PER_W-1:0];
        REG_INV_PERIOD: inv_period_r <= cfg_data[PER_W-1:0];
        REG_INT_LIMIT:  int_limit_r  <= cfg_data[PER_W-1:0];
        REG_SMOOTHING:  smoothing_r  <= cfg_data[SF_W-1:0];
        default: ;
      endcase
    end
  end

  // Operand select: data operand on x, gain operand on y
  always_comb begin
    op_x = '0;
    op_y = '0;
    unique case (op_r)
      OP_SMOOTH: begin
        op_x = {e_r[W-1], e_r} - {prev_r[W-1], prev_r};
        op_y = {{(GAIN_W+1-SF_W){1'b0}}, smoothing_r};
      end
      OP_DERIV: begin
        op_x = {s_r[W-1], s_r} - {prev_r[W-1], prev_r};
        op_y = {{(GAIN_W+1-PER_W){1'b0}}, inv_period_r};
      end
      OP_INTEG: begin
        op_x = {e_r[W-1], e_r};
        op_y = {{(GAIN_W+1-PER_W){1'b0}}, period_r};
      end
      OP_P_TERM: begin
        op_x = {e_r[W-1], e_r};
        op_y = {kp_r[GAIN_W-1], kp_r};
      end
      OP_I_TERM: begin
        op_x = {sum_r[W-1], sum_r};
        op_y = {ki_r[GAIN_W-1], ki_r};
      end
      OP_D_TERM: begin
        op_x = {d_r[W-1], d_r};
        op_y = {kd_r[GAIN_W-1], kd_r};
      end
      default: ;
    endcase
  end

  assign x_abs = op_x[W] ? (~op_x + 1'b1) : op_x;
  assign y_abs = op_y[GAIN_W] ? (~op_y + 1'b1) : op_y;

  // One digit step: add a times the low digit of b into the upper product, shift right
  assign digit_prod = {{DIGIT_W{1'b0}}, a_mag_r} * {{W{1'b0}}, b_mag_r[DIGIT_W-1:0]};
  assign step_sum   = {{DIGIT_W{1'b0}}, prod_r[PW-1:GAIN_W]} + digit_prod;
  assign prod_nxt   = {step_sum, prod_r[GAIN_W-1:DIGIT_W]};

  // Drop fraction bits, round toward minus infinity, saturate to W bits
  assign q_raw   = prod_r[PW-1:FRAC_BITS];
  assign frac_nz = |prod_r[FRAC_BITS-1:0];
  assign q_max   = neg_r ? Q_NEG_MAX : Q_POS_MAX;

  always_comb begin
    if (q_raw > q_max) begin
      q_sat = q_max;
    end else if (neg_r && frac_nz && (q_raw != q_max)) begin
      q_sat = q_raw + Q_ONE;
    end else begin
      q_sat = q_raw;
    end
  end

  assign m_val = neg_r ? (~q_sat[W-1:0] + 1'b1) : q_sat[W-1:0];

  assign m_ext     = {{(LW-W){m_val[W-1]}}, m_val};
  assign prev_ext  = {{(LW-W){prev_r[W-1]}}, prev_r};
  assign integ_ext = {{(LW-W){integ_r[W-1]}}, integ_r};
  assign bias_ext  = {{(LW-GAIN_W){bias_r[GAIN_W-1]}}, bias_r};
  assign err_diff  = {{(LW-32){in_item.target[31]}}, in_item.target}
                   - {{(LW-32){in_item.measured[31]}}, in_item.measured};

  assign lim_ext     = {{(LW-PER_W){1'b0}}, int_limit_r};
  assign neg_lim     = -lim_ext;
  assign sum_pre     = sat_w(integ_ext + m_ext);
  assign sum_pre_ext = {{(LW-W){sum_pre[W-1]}}, sum_pre};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_SMOOTH;
      dig_r       <= '0;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      prev_r      <= '0;
    end else begin
      // drop a taken result unless a new one replaces it this cycle
      if (out_valid_r && !out_stall && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            e_r     <= sat_w(err_diff);
            tot_r   <= bias_ext;
            flag_r  <= 1'b0;
            op_r    <= OP_SMOOTH;
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          a_mag_r <= x_abs[W-1:0];
          b_mag_r <= y_abs[GAIN_W-1:0];
          neg_r   <= op_x[W] ^ op_y[GAIN_W];
          prod_r  <= '0;
          dig_r   <= '0;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          prod_r  <= prod_nxt;
          b_mag_r <= b_mag_r >> DIGIT_W;
          dig_r   <= dig_r + 1'b1;
          if (dig_r == DIG_LAST) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          unique case (op_r) inside
            OP_SMOOTH: s_r <= sat_w(prev_ext + m_ext);
            OP_DERIV:  d_r <= m_val;
            OP_INTEG: begin
              if (sum_pre_ext > lim_ext) begin
                sum_r  <= lim_ext[W-1:0];
                flag_r <= 1'b1;
              end else if (sum_pre_ext < neg_lim) begin
                sum_r  <= neg_lim[W-1:0];
                flag_r <= 1'b1;
              end else begin
                sum_r <= sum_pre;
              end
            end
            OP_P_TERM, OP_I_TERM, OP_D_TERM: tot_r <= tot_r + m_ext;
            default: ;
          endcase
          if (op_r == OP_D_TERM) begin
            state_r <= ST_OUT;
          end else begin
            op_r    <= op_t'(op_r + 1'b1);
            state_r <= ST_LOAD;
          end
        end
        ST_OUT: begin
          // hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            if (tot_r > D_MAX_L) begin
              out_item_r.drive <= D_MAX_L[31:0];
            end else if (tot_r < D_MIN_L) begin
              out_item_r.drive <= D_MIN_L[31:0];
            end else begin
              out_item_r.drive <= tot_r[31:0];
            end
            out_item_r.integral_clamped <= flag_r;
            integ_r <= sum_r;
            prev_r  <= s_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// File: sv/psd_checker.sv
// Port-level assertions for the smoothed-derivative PID block, bound to the top level.
`default_nettype none

module psd_port_checker
  import psd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed or dropped while stalled");

  // One item at a time: the input side closes right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an accept");

  // A new result only comes out of work in progress
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no item in progress");

  // Reset empties the block
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind pid_smoothed_derivative psd_port_checker u_psd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
